// ===== rtl/drde_pkg.sv =====
// ----------------------------------------------------------------------------
// drde_pkg
// Types, codes and constants shared by the dequeue rate and delay estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package drde_pkg;

   localparam int MaxWindow = 64;
   localparam int PtrW      = $clog2(MaxWindow);
   localparam int CntW      = $clog2(MaxWindow + 1);

   localparam int SampleW   = 34;
   localparam int RateW     = 40;
   localparam int DvdW      = 48;
   localparam int DsrW      = 40;

   localparam logic [RateW-1:0] RateMax   = {RateW{1'b1}};
   localparam logic [31:0]      RateReset = 32'd512000;
   localparam logic [9:0]       MsScale   = 10'd1000;
   localparam logic [12:0]      BitMsScale = 13'd8000;

   // floor(x / 1000) for 16-bit x as (x * 67109) >> 26.
   localparam logic [16:0] RecipK    = 17'd67109;
   localparam int          RecipShift = 26;

   localparam logic [1:0] KIND_SENT = 2'd0;
   localparam logic [1:0] KIND_BUSY = 2'd1;
   localparam logic [1:0] KIND_IDLE = 2'd2;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_ARRIVE = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_LINK_KIND = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_MIN_RATE  = 2'd2,
      CSR_AGG_WAIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic            start;
      logic [DvdW-1:0] dividend;
      logic [DsrW-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

// ===== rtl/drde_sample_mem.sv =====
// ----------------------------------------------------------------------------
// drde_sample_mem
// Slot sample store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module drde_sample_mem (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [drde_pkg::PtrW-1:0]     wr_addr,
   input  wire logic [drde_pkg::SampleW-1:0]  wr_data,
   input  wire logic [drde_pkg::PtrW-1:0]     rd_addr,
   output logic      [drde_pkg::SampleW-1:0]  rd_data
);

   logic [drde_pkg::SampleW-1:0] mem_ff [drde_pkg::MaxWindow];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/drde_divider.sv =====
// ----------------------------------------------------------------------------
// drde_divider
// Restoring divider, one quotient bit per cycle. A zero divisor gives an
// all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module drde_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire drde_pkg::div_req_type       req,
   output logic                             done,
   output logic [drde_pkg::DvdW-1:0]        quotient
);

   localparam int StepW = $clog2(drde_pkg::DvdW);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [StepW-1:0]            step_ff, step_in;
   logic [drde_pkg::DsrW:0]     rem_ff, rem_in;
   logic [drde_pkg::DvdW-1:0]   quo_ff, quo_in;
   logic [drde_pkg::DsrW-1:0]   dsr_ff, dsr_in;
   logic [drde_pkg::DsrW:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[drde_pkg::DsrW-1:0], quo_ff[drde_pkg::DvdW-1]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = StepW'(drde_pkg::DvdW - 1);
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[drde_pkg::DvdW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[drde_pkg::DvdW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/dequeue_rate_delay_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// dequeue_rate_delay_estimator_unit
// Estimates dequeue rate, transmit delay and queueing delay from slot ticks,
// arrival notes and delay queries.
//
//   Channel  Direction  Fields
//   req      in         tuser: mode; tdata: tick, query and arrival fields
//   rsp      out        tdata: rate, tx delay, head age, total delay
//   csr      in         write enable, register index, write data
//
// A tick stores its sample in ST_T_UPD, then the window sum reads one sample per
// cycle over the n held slots, and the rate and tx delay divisions run on one
// shared bit-serial divider. A query uses the same divider; an arrival note
// passes through ST_ARR to ST_FIN and an unused mode goes straight to ST_FIN.
// The block is ready for the next item in the same cycle that a result is
// raised, also while it waits; a waiting result stalls only the next result.
// Reset is synchronous; the sample memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module dequeue_rate_delay_estimator_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tdata: sent_bytes_total, queue_bytes, head_valid, head_id, head_dest,
   // extra_count, commit_size
   input  wire logic [151:0]  req_tdata,
   // tuser: mode
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // tdata: rate_bps, tx_delay_us, head_age_ms, total_delay_ms
   output logic [103:0]       rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   localparam int PtrW = drde_pkg::PtrW;
   localparam int CntW = drde_pkg::CntW;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_T_UPD  = 13'b0000000000010,
      ST_T_SUM  = 13'b0000000000100,
      ST_T_RDIV = 13'b0000000001000,
      ST_T_RMUL = 13'b0000000010000,
      ST_T_TDIV = 13'b0000000100000,
      ST_T_FLR  = 13'b0000001000000,
      ST_Q_PREP = 13'b0000010000000,
      ST_Q_MUL  = 13'b0000100000000,
      ST_Q_DIV  = 13'b0001000000000,
      ST_Q_FIN  = 13'b0010000000000,
      ST_ARR    = 13'b0100000000000,
      ST_FIN    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic        link_ff, link_in;
   logic [6:0]  win_ff, win_in;
   logic [31:0] minr_ff, minr_in;
   logic [7:0]  aggw_ff, aggw_in;

   logic [31:0] sent_ff, sent_in;
   logic [31:0] qbytes_ff, qbytes_in;
   logic        hvalid_ff, hvalid_in;
   logic [15:0] hid_ff, hid_in;
   logic [31:0] hdest_ff, hdest_in;
   logic [31:0] extra_ff, extra_in;
   logic        commit_ff, commit_in;

   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [PtrW-1:0]  wp_ff, wp_in;
   logic [31:0]      prev_sent_ff, prev_sent_in;
   logic [39:0]      rate_ff, rate_in;
   logic [15:0]      tx_ff, tx_in;
   logic [15:0]      age_ff, age_in;
   logic [15:0]      last_id_ff, last_id_in;
   logic [31:0]      last_dest_ff, last_dest_in;
   logic [31:0]      prev_q_ff, prev_q_in;

   logic [37:0]      sum_ff, sum_in;
   logic [CntW-1:0]  idle_ff, idle_in;
   logic [CntW-1:0]  busy_ff, busy_in;
   logic [CntW-1:0]  iss_ff, iss_in;
   logic             rd_pend_ff, rd_pend_in;

   logic [31:0]      q_ff, q_in;
   logic [44:0]      qprod_ff, qprod_in;
   logic [47:0]      thr_ff, thr_in;
   logic [6:0]       txk_ff, txk_in;
   logic [31:0]      total_ff, total_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [103:0]     rsp_data_ff, rsp_data_in;

   logic                          mem_we;
   logic [PtrW-1:0]               mem_raddr;
   logic [drde_pkg::SampleW-1:0]  mem_wdata;
   logic [drde_pkg::SampleW-1:0]  mem_rdata;

   drde_pkg::div_req_type         div_req;
   logic                          div_done;
   logic [drde_pkg::DvdW-1:0]     div_quot;

   logic [6:0]       w_eff;
   logic [CntW:0]    cnt_inc;
   logic [CntW-1:0]  active;
   logic [50:0]      rate_prod;
   logic [16:0]      tx_full;
   logic [16:0]      act_k;
   logic [32:0]      txk_prod;
   logic [44:0]      qmul;
   logic             exempt;
   logic [31:0]      qdelay;
   logic [33:0]      total_sum;
   logic [15:0]      head_term;
   logic             issue;

   always_comb begin
      if (win_ff == 7'd0) begin
         w_eff = 7'd1;
      end else if (win_ff > 7'(drde_pkg::MaxWindow)) begin
         w_eff = 7'(drde_pkg::MaxWindow);
      end else begin
         w_eff = win_ff;
      end
   end

   assign cnt_inc   = {1'b0, cnt_ff} + 1'b1;
   assign active    = cnt_ff - idle_ff;
   assign rate_prod = div_quot[40:0] * drde_pkg::MsScale;
   assign tx_full   = w_eff * drde_pkg::MsScale;
   assign act_k     = active * drde_pkg::MsScale;
   assign txk_prod  = tx_ff * drde_pkg::RecipK;
   assign qmul      = q_ff * drde_pkg::BitMsScale;
   assign issue     = (iss_ff < cnt_ff);
   assign exempt    = !link_ff && ({6'b0, qprod_ff} <= {3'b0, thr_ff}) && (q_ff >= prev_q_ff);
   assign head_term = link_ff ? 16'd0 : age_ff;

   always_comb begin
      if (exempt) begin
         qdelay = 32'd0;
      end else if (rate_ff == '0 || div_quot[47:32] != '0) begin
         qdelay = 32'hFFFF_FFFF;
      end else begin
         qdelay = div_quot[31:0];
      end
   end

   assign total_sum = {2'b0, qdelay} + {18'b0, head_term} + {27'b0, txk_ff};

   always_comb begin
      state_in     = state_ff;
      link_in      = link_ff;
      win_in       = win_ff;
      minr_in      = minr_ff;
      aggw_in      = aggw_ff;
      sent_in      = sent_ff;
      qbytes_in    = qbytes_ff;
      hvalid_in    = hvalid_ff;
      hid_in       = hid_ff;
      hdest_in     = hdest_ff;
      extra_in     = extra_ff;
      commit_in    = commit_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      prev_sent_in = prev_sent_ff;
      rate_in      = rate_ff;
      tx_in        = tx_ff;
      age_in       = age_ff;
      last_id_in   = last_id_ff;
      last_dest_in = last_dest_ff;
      prev_q_in    = prev_q_ff;
      sum_in       = sum_ff;
      idle_in      = idle_ff;
      busy_in      = busy_ff;
      iss_in       = iss_ff;
      rd_pend_in   = 1'b0;
      q_in         = q_ff;
      qprod_in     = qprod_ff;
      thr_in       = thr_ff;
      txk_in       = txk_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wdata    = '0;
      mem_raddr    = wp_ff - PtrW'(1) - iss_ff[PtrW-1:0];
      div_req      = '0;

      if (csr_we) begin
         unique case (drde_pkg::csr_index_type'(csr_index))
            drde_pkg::CSR_LINK_KIND: link_in = csr_wdata[0];
            drde_pkg::CSR_WINDOW:    win_in  = csr_wdata[6:0];
            drde_pkg::CSR_MIN_RATE:  minr_in = csr_wdata;
            drde_pkg::CSR_AGG_WAIT:  aggw_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sent_in   = req_tdata[31:0];
               qbytes_in = req_tdata[63:32];
               hvalid_in = req_tdata[64];
               hid_in    = req_tdata[80:65];
               hdest_in  = req_tdata[112:81];
               extra_in  = req_tdata[144:113];
               commit_in = req_tdata[145];
               total_in  = 32'd0;
               unique case (drde_pkg::mode_type'(req_tuser))
                  drde_pkg::MODE_TICK:   state_in = ST_T_UPD;
                  drde_pkg::MODE_QUERY:  state_in = ST_Q_PREP;
                  drde_pkg::MODE_ARRIVE: state_in = ST_ARR;
                  default:               state_in = ST_FIN;
               endcase
            end
         end
         ST_T_UPD: begin
            if (hvalid_ff) begin
               if (hid_ff != last_id_ff || hdest_ff != last_dest_ff) begin
                  last_id_in   = hid_ff;
                  last_dest_in = hdest_ff;
                  age_in       = 16'd0;
               end else if (age_ff != 16'hFFFF) begin
                  age_in = age_ff + 16'd1;
               end
            end else begin
               age_in = 16'd0;
            end
            if (sent_ff > prev_sent_ff) begin
               mem_wdata = {drde_pkg::KIND_SENT, sent_ff - prev_sent_ff};
            end else if (qbytes_ff != 32'd0) begin
               mem_wdata = {drde_pkg::KIND_BUSY, 32'd0};
            end else begin
               mem_wdata = {drde_pkg::KIND_IDLE, 32'd0};
            end
            mem_we       = 1'b1;
            prev_sent_in = sent_ff;
            wp_in        = wp_ff + PtrW'(1);
            cnt_in       = (cnt_inc > {1'b0, w_eff}) ? w_eff : cnt_inc[CntW-1:0];
            sum_in       = '0;
            idle_in      = '0;
            busy_in      = '0;
            iss_in       = '0;
            state_in     = ST_T_SUM;
         end
         ST_T_SUM: begin
            if (issue) begin
               rd_pend_in = 1'b1;
               iss_in     = iss_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               if (mem_rdata[33:32] == drde_pkg::KIND_SENT) begin
                  sum_in = sum_ff + {6'b0, mem_rdata[31:0]};
               end else if (mem_rdata[33:32] == drde_pkg::KIND_BUSY) begin
                  busy_in = busy_ff + 1'b1;
               end else begin
                  idle_in = idle_ff + 1'b1;
               end
            end
            if (!issue && !rd_pend_ff) begin
               if (idle_ff < cnt_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {7'b0, sum_ff, 3'b0};
                  div_req.divisor  = {33'b0, w_eff - idle_ff};
                  state_in         = ST_T_RDIV;
               end else begin
                  state_in = ST_T_FLR;
               end
            end
         end
         ST_T_RDIV: begin
            if (div_done) begin
               state_in = ST_T_RMUL;
            end
         end
         ST_T_RMUL: begin
            rate_in = (rate_prod > {11'b0, drde_pkg::RateMax}) ? drde_pkg::RateMax
                                                                : rate_prod[39:0];
            if (busy_ff < active) begin
               div_req.start    = 1'b1;
               div_req.dividend = {31'b0, act_k};
               div_req.divisor  = {33'b0, active - busy_ff};
               state_in         = ST_T_TDIV;
            end else begin
               tx_in    = tx_full[15:0];
               state_in = ST_T_FLR;
            end
         end
         ST_T_TDIV: begin
            if (div_done) begin
               tx_in    = div_quot[15:0];
               state_in = ST_T_FLR;
            end
         end
         ST_T_FLR: begin
            if (rate_ff < {8'b0, minr_ff}) begin
               rate_in = {8'b0, minr_ff};
            end
            state_in = ST_FIN;
         end
         ST_Q_PREP: begin
            q_in     = (qbytes_ff > extra_ff) ? qbytes_ff - extra_ff : 32'd0;
            state_in = ST_Q_MUL;
         end
         ST_Q_MUL: begin
            qprod_in         = qmul;
            thr_in           = aggw_ff * rate_ff;
            txk_in           = txk_prod[32:drde_pkg::RecipShift];
            div_req.start    = 1'b1;
            div_req.dividend = {3'b0, qmul};
            div_req.divisor  = rate_ff;
            state_in         = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (div_done) begin
               state_in = ST_Q_FIN;
            end
         end
         ST_Q_FIN: begin
            total_in = (total_sum[33:32] != 2'b0) ? 32'hFFFF_FFFF : total_sum[31:0];
            if (commit_ff) begin
               prev_q_in = q_ff;
            end
            state_in = ST_FIN;
         end
         ST_ARR: begin
            last_id_in   = hid_ff;
            last_dest_in = hdest_ff;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {total_ff, age_ff, tx_ff, rate_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         link_ff      <= 1'b1;
         win_ff       <= 7'd40;
         minr_ff      <= drde_pkg::RateReset;
         aggw_ff      <= 8'd5;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         prev_sent_ff <= '0;
         rate_ff      <= {8'b0, drde_pkg::RateReset};
         tx_ff        <= '0;
         age_ff       <= '0;
         last_id_ff   <= '0;
         last_dest_ff <= '0;
         prev_q_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         link_ff      <= link_in;
         win_ff       <= win_in;
         minr_ff      <= minr_in;
         aggw_ff      <= aggw_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         prev_sent_ff <= prev_sent_in;
         rate_ff      <= rate_in;
         tx_ff        <= tx_in;
         age_ff       <= age_in;
         last_id_ff   <= last_id_in;
         last_dest_ff <= last_dest_in;
         prev_q_ff    <= prev_q_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sent_ff     <= sent_in;
      qbytes_ff   <= qbytes_in;
      hvalid_ff   <= hvalid_in;
      hid_ff      <= hid_in;
      hdest_ff    <= hdest_in;
      extra_ff    <= extra_in;
      commit_ff   <= commit_in;
      sum_ff      <= sum_in;
      idle_ff     <= idle_in;
      busy_ff     <= busy_in;
      iss_ff      <= iss_in;
      q_ff        <= q_in;
      qprod_ff    <= qprod_in;
      thr_ff      <= thr_in;
      txk_ff      <= txk_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   drde_sample_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_ff),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   drde_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_T_RDIV || state_ff == ST_T_TDIV || state_ff == ST_Q_DIV))
      else $error("divider finished outside a wait state");

   a_rate_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T_FLR) |=> (rate_ff >= {8'b0, $past(minr_ff)}))
      else $error("rate below floor after tick");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(drde_pkg::MaxWindow))
      else $error("slot count beyond window");

endmodule

`default_nettype wire

// ===== sim/drde_checker.sv =====
// ----------------------------------------------------------------------------
// drde_checker
// Watches the request, result and register write channels of the dequeue
// rate and delay estimator. It keeps its own copy of the estimator state,
// computes the expected result of every accepted item and compares each
// accepted result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module drde_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [151:0]  req_tdata,
   input  wire logic [1:0]    req_tuser,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [103:0]  rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata,
   output int                 fail_count,
   output int                 outstanding,
   output int                 checked
);

   typedef struct {
      logic [39:0] rate;
      logic [15:0] tx_delay;
      logic [15:0] head_age;
      logic [31:0] total_delay;
   } estimate_type;

   estimate_type expected_q[$];

   logic        link_kind;
   logic [6:0]  window_slots;
   logic [31:0] min_rate;
   logic [7:0]  agg_wait;

   logic [33:0] samples [drde_pkg::MaxWindow];
   int unsigned held;
   int unsigned wr_ptr;
   logic [31:0] prev_sent;
   logic [39:0] rate;
   logic [15:0] tx_delay;
   logic [15:0] age;
   logic [15:0] last_id;
   logic [31:0] last_dst;
   logic [31:0] prev_qsize;

   task automatic estimate(input logic [1:0] mode, input logic [151:0] d);
      logic [31:0] sent;
      logic [31:0] qbytes;
      logic        head_valid;
      logic [15:0] id;
      logic [31:0] dst;
      logic [31:0] extra;
      logic        commit;
      logic [33:0] sample;
      int unsigned w;
      int unsigned idle;
      int unsigned busy;
      int unsigned active;
      int unsigned idx;
      longint unsigned sum;
      longint unsigned r;
      longint unsigned thr;
      longint unsigned qd;
      longint unsigned total;
      logic [31:0] q;
      estimate_type e;
      sent       = d[31:0];
      qbytes     = d[63:32];
      head_valid = d[64];
      id         = d[80:65];
      dst        = d[112:81];
      extra      = d[144:113];
      commit     = d[145];
      total      = 0;
      if (mode == drde_pkg::MODE_TICK) begin
         w = (window_slots == 0) ? 1 :
             (window_slots > drde_pkg::MaxWindow) ? drde_pkg::MaxWindow : window_slots;
         if (head_valid) begin
            if (id != last_id || dst != last_dst) begin
               last_id  = id;
               last_dst = dst;
               age      = 0;
            end else if (age != 16'hFFFF) begin
               age = age + 16'd1;
            end
         end else begin
            age = 0;
         end
         if (sent > prev_sent) sample = {drde_pkg::KIND_SENT, sent - prev_sent};
         else if (qbytes != 0) sample = {drde_pkg::KIND_BUSY, 32'd0};
         else sample = {drde_pkg::KIND_IDLE, 32'd0};
         prev_sent = sent;
         samples[wr_ptr] = sample;
         wr_ptr = (wr_ptr + 1) % drde_pkg::MaxWindow;
         held = held + 1;
         if (held > w) held = w;
         sum  = 0;
         idle = 0;
         busy = 0;
         for (int i = 0; i < held; i++) begin
            idx = (wr_ptr + drde_pkg::MaxWindow - 1 - i) % drde_pkg::MaxWindow;
            if (samples[idx][33:32] == drde_pkg::KIND_SENT) sum += samples[idx][31:0];
            else if (samples[idx][33:32] == drde_pkg::KIND_BUSY) busy++;
            else idle++;
         end
         if (idle < held) begin
            r = 1000 * ((sum * 8) / (w - idle));
            active = held - idle;
            rate = (r > drde_pkg::RateMax) ? drde_pkg::RateMax : r[39:0];
            if (busy < active) tx_delay = 16'((1000 * active) / (active - busy));
            else tx_delay = 16'(w * 1000);
         end
         if (rate < min_rate) rate = {8'd0, min_rate};
      end else if (mode == drde_pkg::MODE_QUERY) begin
         q   = (qbytes > extra) ? qbytes - extra : 32'd0;
         thr = 64'(agg_wait) * rate / 1000 / 8;
         if (link_kind == 1'b0 && q <= thr && q >= prev_qsize) qd = 0;
         else if (rate == 0) qd = 64'hFFFF_FFFF;
         else begin
            qd = (64'd8000 * q) / rate;
            if (qd > 64'hFFFF_FFFF) qd = 64'hFFFF_FFFF;
         end
         total = qd + ((link_kind == 1'b0) ? age : 16'd0) + tx_delay / 1000;
         if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
         if (commit) prev_qsize = q;
      end else if (mode == drde_pkg::MODE_ARRIVE) begin
         last_id  = id;
         last_dst = dst;
      end
      e.rate        = rate;
      e.tx_delay    = tx_delay;
      e.head_age    = age;
      e.total_delay = total[31:0];
      expected_q.insert(expected_q.size(), e);
   endtask

   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         link_kind    = 1'b1;
         window_slots = 7'd40;
         min_rate     = drde_pkg::RateReset;
         agg_wait     = 8'd5;
         held         = 0;
         wr_ptr       = 0;
         prev_sent    = 0;
         rate         = {8'd0, drde_pkg::RateReset};
         tx_delay     = 0;
         age          = 0;
         last_id      = 0;
         last_dst     = 0;
         prev_qsize   = 0;
         expected_q.delete();
         fail_count   = 0;
         checked      = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("result with no expected item waiting");
               fail_count++;
            end else begin
               e = expected_q[0];
               expected_q.delete(0);
               checked++;
               if (rsp_tdata[39:0] !== e.rate) begin
                  $error("rate_bps: expected %0d, actual %0d", e.rate, rsp_tdata[39:0]);
                  fail_count++;
               end
               if (rsp_tdata[55:40] !== e.tx_delay) begin
                  $error("tx_delay_us: expected %0d, actual %0d", e.tx_delay,
                     rsp_tdata[55:40]);
                  fail_count++;
               end
               if (rsp_tdata[71:56] !== e.head_age) begin
                  $error("head_age_ms: expected %0d, actual %0d", e.head_age,
                     rsp_tdata[71:56]);
                  fail_count++;
               end
               if (rsp_tdata[103:72] !== e.total_delay) begin
                  $error("total_delay_ms: expected %0d, actual %0d", e.total_delay,
                     rsp_tdata[103:72]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) estimate(req_tuser, req_tdata);
         if (csr_we) begin
            case (csr_index)
               drde_pkg::CSR_LINK_KIND: link_kind    = csr_wdata[0];
               drde_pkg::CSR_WINDOW:    window_slots = csr_wdata[6:0];
               drde_pkg::CSR_MIN_RATE:  min_rate     = csr_wdata;
               drde_pkg::CSR_AGG_WAIT:  agg_wait     = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_q.size();
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top for the dequeue rate and delay estimator. It drives slot
// ticks, delay queries, arrival notes and unused-mode items with random gaps
// and result stalls over several register settings, including one long result
// hold-off, and reports the verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [151:0]  req_tdata = '0;
   logic [1:0]    req_tuser = drde_pkg::MODE_TICK;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = drde_pkg::CSR_LINK_KIND;
   logic [31:0]   csr_wdata = '0;

   int fail_count;
   int outstanding;
   int checked;
   int mode_count [4];
   int settings_count;
   bit calm;
   bit hold_req;
   logic [31:0] sent_total;
   logic [15:0] cur_id;
   logic [31:0] cur_dst;

   logic        set_lk [8]   = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   logic [6:0]  set_win [8]  = '{7'd40, 7'd1, 7'd64, 7'd0, 7'd127, 7'd8, 7'd64, 7'd100};
   logic [31:0] set_minr [8] = '{32'd512000, 32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd0,
                                 32'd100000, 32'd512000, 32'd0};
   logic [7:0]  set_agg [8]  = '{8'd5, 8'd255, 8'd0, 8'd1, 8'd200, 8'd20, 8'd5, 8'd255};

   always #1 clock = ~clock;

   dequeue_rate_delay_estimator_unit u_dut (.*);

   drde_checker u_checker (.*);

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always begin
      @(negedge clock);
      if (!reset) begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            hold_req = 1'b0;
            repeat (400) @(negedge clock);
         end
         if (!calm) begin
            int stall;
            stall = $urandom_range(16);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send(input logic [1:0] mode, input logic [31:0] sent, input logic [31:0] qb,
                       input logic hv, input logic [15:0] id, input logic [31:0] dst,
                       input logic [31:0] extra, input logic commit);
      int gap;
      gap = calm ? 0 : $urandom_range(16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {6'd0, commit, extra, dst, id, hv, qb, sent};
      req_tuser  <= mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      mode_count[mode]++;
   endtask

   task automatic configure(input logic lk, input logic [6:0] win, input logic [31:0] minr,
                            input logic [7:0] agg);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= drde_pkg::CSR_LINK_KIND;
      csr_wdata <= {31'd0, lk};
      @(negedge clock);
      csr_index <= drde_pkg::CSR_WINDOW;
      csr_wdata <= {25'd0, win};
      @(negedge clock);
      csr_index <= drde_pkg::CSR_MIN_RATE;
      csr_wdata <= minr;
      @(negedge clock);
      csr_index <= drde_pkg::CSR_AGG_WAIT;
      csr_wdata <= {24'd0, agg};
      @(negedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   task automatic random_item();
      int pick;
      int r;
      logic [31:0] qb;
      logic [31:0] extra;
      pick = $urandom_range(99);
      r = $urandom_range(99);
      if (pick < 60) begin
         if (r < 60) sent_total = sent_total + $urandom_range(3000);
         else if (r < 70) sent_total = sent_total + $urandom_range(200000);
         else if (r < 75) sent_total = sent_total + $urandom;
         else if (r < 80) sent_total = sent_total - $urandom_range(5000);
         qb = ($urandom_range(2) == 0) ? 32'd0 :
              ($urandom_range(4) == 0) ? $urandom : $urandom_range(50000);
         if ($urandom_range(9) == 0) begin
            cur_id  = 16'($urandom);
            cur_dst = $urandom;
         end
         send(drde_pkg::MODE_TICK, sent_total, qb, $urandom_range(7) != 0, cur_id, cur_dst,
              $urandom, 1'($urandom_range(1)));
      end else if (pick < 85) begin
         qb = (r < 70) ? $urandom_range(4000) : $urandom;
         extra = (r % 3 == 0) ? $urandom : $urandom_range(1500);
         send(drde_pkg::MODE_QUERY, $urandom, qb, 1'($urandom_range(1)), 16'($urandom),
              $urandom, extra, 1'($urandom_range(1)));
      end else if (pick < 95) begin
         if (r < 50) begin
            cur_id  = 16'($urandom);
            cur_dst = $urandom;
         end
         send(drde_pkg::MODE_ARRIVE, $urandom, $urandom, 1'($urandom_range(1)), cur_id,
              cur_dst, $urandom, 1'($urandom_range(1)));
      end else begin
         send(pick < 97 ? drde_pkg::MODE_NOP : 2'($urandom_range(3)), $urandom, $urandom,
              1'($urandom_range(1)), 16'($urandom), $urandom, $urandom,
              1'($urandom_range(1)));
      end
   endtask

   initial begin
      sent_total = 0;
      cur_id = 16'h1234;
      cur_dst = 32'h0A00_0001;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(drde_pkg::MODE_TICK, 32'd0, 32'd0, 1'b0, 16'd0, 32'd0, 32'd0, 1'b0);
      send(drde_pkg::MODE_TICK, 32'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
           1'b0);
      send(drde_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 1'b1);
      send(drde_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'd100, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
           1'b0);
      send(drde_pkg::MODE_TICK, 32'd10, 32'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
      send(drde_pkg::MODE_QUERY, 32'd0, 32'd0, 1'b0, 16'd0, 32'd0, 32'd0, 1'b1);
      send(drde_pkg::MODE_QUERY, 32'd0, 32'hFFFF_FFFF, 1'b0, 16'd0, 32'd0, 32'd0, 1'b0);
      send(drde_pkg::MODE_QUERY, 32'd0, 32'd100, 1'b0, 16'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
      send(drde_pkg::MODE_ARRIVE, 32'd0, 32'd0, 1'b0, 16'h00AA, 32'h0102_0304, 32'd0, 1'b0);
      send(drde_pkg::MODE_TICK, 32'd5000, 32'd10, 1'b1, 16'h00AA, 32'h0102_0304, 32'd0, 1'b0);
      send(drde_pkg::MODE_TICK, 32'd9000, 32'd10, 1'b1, 16'h00AA, 32'h0102_0304, 32'd0, 1'b0);
      send(drde_pkg::MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 1'b1);
      send(drde_pkg::MODE_TICK, 32'd9000, 32'd0, 1'b0, 16'h00AA, 32'h0102_0304, 32'd0, 1'b0);
      send(drde_pkg::MODE_QUERY, 32'd0, 32'd2000, 1'b1, 16'd0, 32'd0, 32'd500, 1'b0);
      sent_total = 32'd9000;

      for (int p = 0; p < 8; p++) begin
         configure(set_lk[p], set_win[p], set_minr[p], set_agg[p]);
         calm = (p == 2 || p == 5);
         if (p == 0) hold_req = 1'b1;
         if (set_lk[p] == 1'b0) begin
            send(drde_pkg::MODE_QUERY, 32'd0, 32'd0, 1'b0, 16'd0, 32'd0, 32'd0, 1'b1);
            send(drde_pkg::MODE_QUERY, 32'd0, 32'd300, 1'b0, 16'd0, 32'd0, 32'd0, 1'b0);
         end
         for (int i = 0; i < 190; i++) random_item();
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("Sent %0d ticks, %0d queries, %0d arrival notes and %0d unused-mode items",
               mode_count[drde_pkg::MODE_TICK], mode_count[drde_pkg::MODE_QUERY],
               mode_count[drde_pkg::MODE_ARRIVE], mode_count[drde_pkg::MODE_NOP]);
      $display("over %0d register settings; %0d results were compared.", settings_count,
               checked);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/drde_pkg.sv
rtl/drde_sample_mem.sv
rtl/drde_divider.sv
rtl/dequeue_rate_delay_estimator_unit.sv
sim/drde_checker.sv
sim/tb.sv
